[rtl/sha256_stream_hash_top_macros.svh]
// Assertion macros for the top level of the SHA-256 stream hash.
`ifndef SHA256_STREAM_HASH_TOP_MACROS_SVH
`define SHA256_STREAM_HASH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define SHA256_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define SHA256_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sha256_pkg.sv]
// Types and constants shared by the SHA-256 stream hash modules.
package sha256_pkg;

	// One message request: a byte, its presence flag and the end marker.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_item_t;

	// One digest request.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	typedef logic [7:0][31:0] hash_t;

	// Controls for the message buffer and schedule window.
	typedef struct packed {
		logic       load_byte;
		logic [7:0] byte_val;
		logic       shift_word;
	} sched_ctrl_t;

	// Controls for the round unit and hash registers.
	typedef struct packed {
		logic       round_en;
		logic [5:0] round_idx;
		logic       fin_en;
		logic       reinit;
	} core_ctrl_t;

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

[rtl/sha256_ifs.sv]
// Valid/ready channel interfaces for message bytes and digest words.
interface sha256_msg_if;
	import sha256_pkg::*;
	logic      valid;
	logic      ready;
	msg_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sha256_dig_if;
	import sha256_pkg::*;
	logic      valid;
	logic      ready;
	dig_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/sha256_sched.sv]
// Block buffer that doubles as the sliding sixteen-word message schedule.
module sha256_sched (
	input  logic                     clk,
	input  sha256_pkg::sched_ctrl_t  ctrl,
	output logic [31:0]              w_cur
);
	import sha256_pkg::*;

	logic [511:0] buf_q;
	logic [31:0]  w1, w9, w14, w_new;

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	// Word k of the window sits k words below the top; word 0 is the current one.
	assign w_cur = buf_q[511:480];
	assign w1    = buf_q[479:448];
	assign w9    = buf_q[223:192];
	assign w14   = buf_q[63:32];
	assign w_new = small_s1(w14) + w9 + small_s0(w1) + w_cur;

	always_ff @(posedge clk) begin
		if (ctrl.load_byte) begin
			buf_q <= {buf_q[503:0], ctrl.byte_val};
		end else if (ctrl.shift_word) begin
			buf_q <= {buf_q[479:0], w_new};
		end
	end

endmodule

[rtl/sha256_core.sv]
// Shared SHA-256 round unit with the working and hash registers.
module sha256_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha256_pkg::core_ctrl_t  ctrl,
	input  logic [31:0]             w_cur,
	output sha256_pkg::hash_t       hash
);
	import sha256_pkg::*;

	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [31:0] sum [8];
	logic [31:0] t1, t2, big_s0, big_s1, ch, maj;

	assign big_s1 = {work_q[4][5:0], work_q[4][31:6]} ^ {work_q[4][10:0], work_q[4][31:11]}
		^ {work_q[4][24:0], work_q[4][31:25]};
	assign big_s0 = {work_q[0][1:0], work_q[0][31:2]} ^ {work_q[0][12:0], work_q[0][31:13]}
		^ {work_q[0][21:0], work_q[0][31:22]};
	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + big_s1 + ch + ROUND_K[ctrl.round_idx] + w_cur;
	assign t2  = big_s0 + maj;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sum[i] = hash_q[i] + work_q[i];
			hash[i] = hash_q[i];
		end
	end

	// The working words always leave a block equal to the new hash, so the
	// next block starts its rounds without a separate load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= HASH_IV[i];
				work_q[i] <= HASH_IV[i];
			end
		end else if (ctrl.reinit) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= HASH_IV[i];
				work_q[i] <= HASH_IV[i];
			end
		end else if (ctrl.fin_en) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sum[i];
				work_q[i] <= sum[i];
			end
		end else if (ctrl.round_en) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

endmodule

[rtl/sha256_stream_hash_top.sv]
// Top level of the SHA-256 stream hash: sequencer, padding, length count and digest output.
//
// The block hashes a message that arrives one byte per request on msg and
// returns the 256-bit digest as eight 32-bit requests on dig, most significant
// word first, with word_index counting 0 to 7 and last_word high on the
// eighth. A request with byte_present low and end_of_message high ends the
// message without adding a byte, so an empty message is hashed correctly; a
// request with neither flag set is taken and has no effect. A byte request is
// taken with msg staying ready unless it completes a 64-byte block, in which
// case the block is compressed by a single shared round unit, one round per
// cycle, and msg stays not ready through the 64 rounds and the step that adds
// the working words into the hash. On the end request the block feeds the
// padding through the same byte path, one byte per cycle, up to the end of the
// current block or of the next one when the 0x80 marker falls in the last
// eight byte positions; each block so filled is compressed the same way. The
// eight digest words then wait on dig, one per accepted request, and msg is
// not ready until the last has been taken, after which the hash state is back
// at its initial values and the next byte starts a new message. The bit length
// is held in 64 bits and wraps. The message buffer and the sixteen-word
// schedule window are one shift register, so there is no memory and no
// clearing pass after reset.
`include "sha256_stream_hash_top_macros.svh"

module sha256_stream_hash_top (
	input  logic               clk,
	input  logic               arst_n,
	sha256_msg_if.sink         msg,
	sha256_dig_if.source       dig
);
	import sha256_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        end_pend_q;   // the message has ended and padding is under way
	logic        pad_sent_q;   // the 0x80 marker byte has been placed
	logic        len_ok_q;     // the current block carries the length field
	logic        last_blk_q;   // the block being compressed is the final one

	logic        msg_acc, dig_acc;
	logic        push_en, wrap, is_len;
	logic [7:0]  push_val;
	logic [7:0][7:0] len_bytes;
	logic [31:0] w_cur;
	hash_t       hash;
	sched_ctrl_t sched_ctrl;
	core_ctrl_t  core_ctrl;

	assign msg.ready = (state_q == ST_IDLE);
	assign msg_acc   = msg.valid && msg.ready;
	assign dig.valid = (state_q == ST_OUT);
	assign dig_acc   = dig.valid && dig.ready;

	assign dig.payload.digest_word = hash[oidx_q];
	assign dig.payload.word_index  = oidx_q;
	assign dig.payload.last_word   = (oidx_q == 3'd7);

	// Length bytes go out big-endian in the last eight positions of the block.
	assign len_bytes = bits_q;
	assign is_len    = pad_sent_q && len_ok_q && (fill_q[5:3] == LEN_POS[5:3]);

	always_comb begin
		push_en  = 1'b0;
		push_val = msg.payload.data_byte;
		if (state_q == ST_IDLE) begin
			push_en = msg_acc && msg.payload.byte_present;
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (!pad_sent_q) begin
				push_val = PAD_BYTE;
			end else if (is_len) begin
				push_val = len_bytes[3'd7 - fill_q[2:0]];
			end else begin
				push_val = 8'h00;
			end
		end
	end

	assign wrap = push_en && (fill_q == 6'd63);

	assign sched_ctrl.load_byte  = push_en;
	assign sched_ctrl.byte_val   = push_val;
	assign sched_ctrl.shift_word = (state_q == ST_COMP);

	assign core_ctrl.round_en  = (state_q == ST_COMP);
	assign core_ctrl.round_idx = rnd_q;
	assign core_ctrl.fin_en    = (state_q == ST_FIN);
	assign core_ctrl.reinit    = dig_acc && dig.payload.last_word;

	sha256_sched u_sched (
		.clk   (clk),
		.ctrl  (sched_ctrl),
		.w_cur (w_cur)
	);

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.w_cur  (w_cur),
		.hash   (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			bits_q     <= '0;
			rnd_q      <= '0;
			oidx_q     <= '0;
			end_pend_q <= 1'b0;
			pad_sent_q <= 1'b0;
			len_ok_q   <= 1'b0;
			last_blk_q <= 1'b0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						end_pend_q <= msg.payload.end_of_message;
						if (msg.payload.byte_present) begin
							bits_q <= bits_q + 64'd8;
						end
						if (wrap) begin
							state_q <= ST_COMP;
						end else if (msg.payload.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_sent_q <= 1'b1;
					// The marker leaves room for the length in its own block
					// only when it lands before the length field.
					if (!pad_sent_q && (fill_q[5:3] != LEN_POS[5:3])) begin
						len_ok_q <= 1'b1;
					end
					if (wrap) begin
						last_blk_q <= is_len;
						state_q    <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (last_blk_q) begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end else if (end_pend_q) begin
						if (pad_sent_q) begin
							len_ok_q <= 1'b1;
						end
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						if (dig.payload.last_word) begin
							fill_q     <= '0;
							bits_q     <= '0;
							end_pend_q <= 1'b0;
							pad_sent_q <= 1'b0;
							len_ok_q   <= 1'b0;
							last_blk_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// While digest words are on offer no message request may be taken.
	`SHA256_ASSERT_IMP(a_no_overlap, dig.valid, !msg.ready, "message taken during digest output")

	// Digest words leave in order with no gap in the index.
	`SHA256_ASSERT_NXT(a_word_order, dig_acc && !dig.payload.last_word,
		dig.valid && (dig.payload.word_index == 3'($past(dig.payload.word_index) + 3'd1)),
		"digest word index out of order")

	// After the last word the block is ready for a fresh message.
	`SHA256_ASSERT_NXT(a_reinit, dig_acc && dig.payload.last_word,
		msg.ready && (fill_q == 6'd0) && (bits_q == 64'd0),
		"state not reinitialised after digest")

	// The round counter steps once per cycle through a compression.
	`SHA256_ASSERT_NXT(a_round_step, (state_q == ST_COMP) && (rnd_q != 6'd63),
		(state_q == ST_COMP) && (rnd_q == 6'($past(rnd_q) + 6'd1)),
		"compression rounds interrupted")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the SHA-256 stream hash: random byte streams against a local digest model.
`timescale 1ns / 100ps

module testbench;
	import sha256_pkg::msg_item_t;
	import sha256_pkg::dig_item_t;

	// Pacing: in phase 0 the sender idles rarely and the receiver often, in
	// phase 1 the other way round, and in phase 2 nobody idles at all.
	localparam int TX_IDLE [3] = '{11, 66, 0};
	localparam int RX_IDLE [3] = '{66, 11, 0};

	// Each random phase opens with one message whose length sits on a
	// padding boundary: 55 bytes leave just room for the marker and the
	// length field, 56 bytes push the length into an extra block, and 64
	// bytes fill a block exactly before the padding starts.
	localparam int EDGE_LEN [3] = '{55, 56, 64};
	localparam int PHASE_REQUESTS = 60;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 150;
	localparam int STALL_LIMIT  = 3000;

	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam int         LEN_FIELD_AT = 56;

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// A request waiting to be offered, with the pacing phase it belongs to.
	// A request marked wait_drain is held back until every digest word
	// already owed has arrived; one marked hold_rx makes the receiver stall
	// for a long stretch once the request has been taken.
	typedef struct {
		msg_item_t  item;
		int         pace;
		bit         wait_drain;
		bit         hold_rx;
	} queued_request_t;

	logic clk;
	logic arst_n = 1'b0;

	sha256_msg_if msg_ch ();
	sha256_dig_if dig_ch ();

	sha256_stream_hash_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.dig    (dig_ch)
	);

	queued_request_t request_queue [$];
	queued_request_t in_flight;
	dig_item_t       digest_due [$];

	int pace_now       = 0;
	int hold_orders    = 0;
	int holds_begun    = 0;
	int hold_left      = 0;
	int requests_queued = 0;
	int messages_hashed = 0;
	int bytes_hashed    = 0;
	int words_checked   = 0;
	int faults          = 0;
	int quiet_cycles    = 0;

	// Local copy of the hash state: chaining words, the partly filled
	// block, its fill level and the running message length in bits.
	logic [31:0] hash_chain [8];
	logic [7:0]  block_bytes [64];
	int          block_fill;
	logic [63:0] length_bits;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_restart();
		for (int i = 0; i < 8; i++)
			hash_chain[i] = START_HASH[i];
		block_fill  = 0;
		length_bits = '0;
	endfunction

	// The standard 64 rounds over the full block, with the whole message
	// schedule expanded up front.
	function automatic void sha_compress();
		logic [31:0] sched [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, big0, big1, choose, major;
		for (int i = 0; i < 16; i++)
			sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
				block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			sched[i] = sched[i-16] + sched[i-7]
				+ (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
				+ (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = hash_chain[i];
		for (int i = 0; i < 64; i++) begin
			big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1     = v[7] + big1 + choose + ROUND_CONST[i] + sched[i];
			big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2     = big0 + major;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_chain[i] += v[i];
	endfunction

	function automatic void sha_push(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		if (block_fill == 64) begin
			sha_compress();
			block_fill = 0;
		end
	endfunction

	// Folds one accepted request into the model. A byte is appended before
	// the end marker is acted on; an end pads the message, queues the eight
	// digest words that are now owed and starts a fresh message.
	function automatic void sha_absorb(input msg_item_t req);
		logic [63:0] len_snap;
		dig_item_t   word;
		if (req.byte_present) begin
			length_bits += 64'd8;
			sha_push(req.data_byte);
			bytes_hashed++;
		end
		if (req.end_of_message) begin
			len_snap = length_bits;
			sha_push(PAD_MARK);
			while (block_fill != LEN_FIELD_AT)
				sha_push(8'h00);
			for (int i = 0; i < 8; i++)
				sha_push(len_snap[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				word.digest_word = hash_chain[i];
				word.word_index  = 3'(i);
				word.last_word   = (i == 7);
				digest_due.push_back(word);
			end
			messages_hashed++;
			sha_restart();
		end
	endfunction

	task automatic queue_request(input logic [7:0] data, input bit present, input bit ends,
			input int pace, input bit wait_drain, input bit hold_rx);
		queued_request_t r;
		r.item.data_byte      = data;
		r.item.byte_present   = present;
		r.item.end_of_message = ends;
		r.pace       = pace;
		r.wait_drain = wait_drain;
		r.hold_rx    = hold_rx;
		request_queue.push_back(r);
		if (present || ends)
			requests_queued++;
	endtask

	// One message of random bytes. The end is either carried on the last
	// byte or sent as a separate end-only request, and now and then an idle
	// request with neither flag set is slipped in between.
	task automatic queue_message(input int len, input int pace, input bit wait_drain);
		bit joined;
		bit drain_flag;
		joined     = (len > 0) && ($urandom_range(1) == 1);
		drain_flag = wait_drain;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 8)
				queue_request(8'($urandom), 1'b0, 1'b0, pace, 1'b0, 1'b0);
			queue_request(8'($urandom), 1'b1, joined && (k == len - 1), pace, drain_flag, 1'b0);
			drain_flag = 1'b0;
		end
		if (!joined)
			queue_request(8'($urandom), 1'b0, 1'b1, pace, drain_flag, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sender. A request is dropped from the queue as soon as it is put on
	// the bus and is folded into the model only on the edge at which it is
	// taken; the payload stays put while the block holds off.
	always @(posedge clk or negedge arst_n) begin : msg_driver
		bit offer;
		if (!arst_n) begin
			msg_ch.valid   <= 1'b0;
			msg_ch.payload <= '0;
			pace_now       <= 0;
			hold_orders    <= 0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				sha_absorb(msg_ch.payload);
				if (in_flight.hold_rx)
					hold_orders <= hold_orders + 1;
			end
			if (!msg_ch.valid || msg_ch.ready) begin
				offer = request_queue.size() != 0
					&& (!request_queue[0].wait_drain || digest_due.size() == 0)
					&& $urandom_range(99) >= TX_IDLE[request_queue[0].pace];
				if (offer) begin
					in_flight = request_queue.pop_front();
					msg_ch.valid   <= 1'b1;
					msg_ch.payload <= in_flight.item;
					pace_now       <= in_flight.pace;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. A hold order keeps ready low for a long count of its own,
	// long enough for the block to run out of room and refuse message bytes
	// while the sender keeps offering them.
	always @(posedge clk or negedge arst_n) begin : dig_receiver
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			hold_left    <= 0;
			holds_begun  <= 0;
		end else if (holds_begun != hold_orders) begin
			dig_ch.ready <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			holds_begun  <= holds_begun + 1;
		end else if (hold_left != 0) begin
			dig_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			dig_ch.ready <= ($urandom_range(99) >= RX_IDLE[pace_now]);
		end
	end

	// Every digest word taken is checked against the oldest word owed.
	always @(posedge clk) begin : dig_monitor
		dig_item_t due;
		if (arst_n && dig_ch.valid && dig_ch.ready) begin
			if (digest_due.size() == 0) begin
				if (faults < 10)
					$display("%0t: digest word %h index %0d last %0b arrived with none owed",
						$realtime, dig_ch.payload.digest_word, dig_ch.payload.word_index,
						dig_ch.payload.last_word);
				faults++;
			end else begin
				due = digest_due.pop_front();
				words_checked++;
				if (dig_ch.payload.digest_word !== due.digest_word
						|| dig_ch.payload.word_index !== due.word_index
						|| dig_ch.payload.last_word !== due.last_word) begin
					if (faults < 10)
						$display("%0t: digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
							$realtime, due.digest_word, due.word_index, due.last_word,
							dig_ch.payload.digest_word, dig_ch.payload.word_index,
							dig_ch.payload.last_word);
					faults++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no request taken on either side
	// means the block has hung.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request taken for %0d cycles", $realtime, STALL_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int mark;
		sha_restart();

		// Directed opening. An idle request first, which must change
		// nothing, then the empty message.
		queue_request(8'hFF, 1'b0, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'h00, 1'b0, 1'b1, 0, 1'b0, 1'b0);
		// One-byte messages with the byte and the end together, at both
		// extremes of the byte. The receiver stalls hard after the second,
		// so the bytes that follow pile up against a full block.
		queue_request(8'h00, 1'b1, 1'b1, 0, 1'b0, 1'b0);
		queue_request(8'hFF, 1'b1, 1'b1, 0, 1'b0, 1'b1);
		// "abc" with an idle request in the middle and a separate end.
		queue_request(8'h61, 1'b1, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'h62, 1'b1, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'h5A, 1'b0, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'h63, 1'b1, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'hA5, 1'b0, 1'b1, 0, 1'b0, 1'b0);
		// Two empty messages back to back: the state must be fresh again
		// straight after a digest.
		queue_request(8'h3C, 1'b0, 1'b1, 0, 1'b0, 1'b0);
		queue_request(8'hC3, 1'b0, 1'b1, 0, 1'b0, 1'b0);
		queue_request(8'h80, 1'b1, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'h7F, 1'b1, 1'b0, 0, 1'b0, 1'b0);
		queue_request(8'h01, 1'b1, 1'b1, 0, 1'b0, 1'b0);

		// Random phases. The first message of each waits for the block to
		// drain completely before it is offered.
		for (int p = 0; p < 3; p++) begin
			mark = requests_queued;
			queue_message(EDGE_LEN[p], p, 1'b1);
			while (requests_queued - mark < PHASE_REQUESTS)
				queue_message($urandom_range(12), p, 1'b0);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || msg_ch.valid || digest_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		faults += digest_due.size();
		$display("Hashed %0d messages (%0d bytes, %0d requests) over three pacing phases,",
			messages_hashed, bytes_hashed, requests_queued);
		$display("padding boundaries and a long receiver stall; %0d digest words compared.",
			words_checked);
		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_ifs.sv
rtl/sha256_sched.sv
rtl/sha256_core.sv
rtl/sha256_stream_hash_top.sv
tb/testbench.sv
